// File: design/frame_deque_pair_timestamp_matcher_unit_defines.svh
// Assertion helpers for the frame deque matcher
`ifndef FRAME_DEQUE_PAIR_TIMESTAMP_MATCHER_UNIT_DEFINES_SVH
`define FRAME_DEQUE_PAIR_TIMESTAMP_MATCHER_UNIT_DEFINES_SVH

// property that must hold on every clock outside reset
`define FDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked on the next clock
`define FDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fdq_pkg.sv
`default_nettype none
package fdq_pkg;
  localparam int QueueDepth = 16;
  localparam int IdxBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int HandleBits = 16;
  localparam int TimeBits   = 52;
  localparam int SecBits    = 32;
  localparam int UsecBits   = 20;
  localparam int LimBits    = 20;
  localparam logic [UsecBits-1:0] UsecPerSec = 20'd1000000;

  typedef enum logic [2:0] {
    OP_ENQ = 3'd0, OP_POP_HEAD = 3'd1, OP_POP_TAIL = 3'd2, OP_PEEK = 3'd3,
    OP_MATCH = 3'd4, OP_CLEAR = 3'd5, OP_INIT = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_CLOSED = 3'd2, ST_EMPTY = 3'd3,
    ST_NOMATCH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_CAP0 = 2'd0, REG_CAP1 = 2'd1, REG_EARLY = 2'd2, REG_MAXD = 2'd3
  } reg_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic                 we;
    logic                 wq;
    logic [IdxBits-1:0]   waddr;
    logic [HandleBits-1:0] whandle;
    logic [TimeBits-1:0]  wtime;
    logic [IdxBits-1:0]   raddr0;
    logic [IdxBits-1:0]   raddr1;
  } mem_req_t;

  typedef struct packed {
    logic [HandleBits-1:0] h0;
    logic [TimeBits-1:0]   t0;
    logic [HandleBits-1:0] h1;
    logic [TimeBits-1:0]   t1;
  } mem_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PRE, S_RD, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;
endpackage
`default_nettype wire

// File: design/frame_deque_pair_timestamp_matcher_unit.sv
`default_nettype none
// Two bounded descriptor queues (handle plus capture time in microseconds)
// with enqueue, pop head, pop tail, peek, clear, init and nearest-time pair
// match. One operation is taken at a time and yields one result beat. Enqueue
// forms the time with a registered 32x20 multiply before the write; a refused
// enqueue skips the multiply. Pop head and match close the gap by moving every
// later entry one place, each by a read and then a write, one queue at a time.
// Match scans queue 0 against queue 1 one pair per cycle through the memory
// read ports, at most n0*n1 pairs, then compacts. The output register lets
// the next beat in while a result waits; a second result waits in the last
// state until the first is taken.
module frame_deque_pair_timestamp_matcher_unit import fdq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op[2:0], queue_select[3], frame_handle[19:4], stamp_sec[51:20],
  // stamp_usec[71:52]
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], handle_a[18:3], handle_b[34:19], delta_us[86:35],
  // entry_count[91:87]
  output logic [95:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
`include "frame_deque_pair_timestamp_matcher_unit_defines.svh"

  logic [CntBits-1:0] cap0_r, cap1_r;
  logic [LimBits-1:0] early_r, maxd_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap0_r <= CntBits'(16); cap1_r <= CntBits'(16);
      early_r <= 20'd400; maxd_r <= 20'd50000;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_CAP0:  cap0_r <= cfg_data[CntBits-1:0];
        REG_CAP1:  cap1_r <= cfg_data[CntBits-1:0];
        REG_EARLY: early_r <= cfg_data;
        REG_MAXD:  maxd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  op_t op_r;
  logic q_r;
  logic [HandleBits-1:0] hin_r;
  logic [SecBits-1:0] sec_r;
  logic [UsecBits-1:0] usec_r;
  logic [TimeBits-1:0] prod_r;
  logic [CntBits-1:0] fill0_r, fill1_r;
  logic closed0_r, closed1_r;
  logic [IdxBits-1:0] i_r, j_r, bi_r, bj_r;
  logic [TimeBits:0] best_r;
  logic shq_r;          // queue being compacted
  logic [CntBits-1:0] sh_r;  // destination index of compaction
  logic sh_both_r;      // match: compact queue 1 after queue 0
  logic [2:0] st_r;
  logic [HandleBits-1:0] ha_r, hb_r;
  logic [TimeBits-1:0] dl_r;
  logic ov_r;
  logic [95:0] od_r;

  mem_req_t req;
  mem_rsp_t rsp;
  fdq_store u_store (.clk(clk), .req(req), .rsp(rsp));

  logic [CntBits-1:0] nsel, capsel, cap_eff;
  logic closed_sel, cap_ok;
  logic [TimeBits-1:0] dpair;
  logic [CntBits-1:0] shfill;
  assign nsel = q_r ? fill1_r : fill0_r;
  assign capsel = q_r ? cap1_r : cap0_r;
  assign cap_eff = (capsel > CntBits'(QueueDepth)) ? CntBits'(QueueDepth) : capsel;
  assign closed_sel = q_r ? closed1_r : closed0_r;
  assign cap_ok = nsel < cap_eff;
  assign dpair = (rsp.t1 >= rsp.t0) ? rsp.t1 - rsp.t0 : rsp.t0 - rsp.t1;
  assign shfill = shq_r ? fill1_r : fill0_r;

  logic last_j, last_i;
  assign last_j = {1'b0, j_r} == fill1_r - 1'b1;
  assign last_i = {1'b0, i_r} == fill0_r - 1'b1;

  // running best pair and end of scan
  logic [TimeBits:0] best_nxt;
  logic better, scan_end;
  assign better = best_r[TimeBits] || (dpair < best_r[TimeBits-1:0]);
  assign best_nxt = better ? {1'b0, dpair} : best_r;
  assign scan_end = last_j && (last_i || best_nxt[TimeBits-1:0] < TimeBits'(early_r));

  assign in_tready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid && in_tready) state_nxt = S_PRE;
      S_PRE: begin
        unique case (op_r)
          OP_ENQ:   state_nxt = closed_sel ? S_DONE : (cap_ok ? S_MUL : S_DONE);
          OP_POP_HEAD, OP_POP_TAIL, OP_PEEK: state_nxt = S_RD;
          OP_MATCH: state_nxt = (fill0_r == '0 || fill1_r == '0) ? S_DONE : S_RD;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_MUL:   state_nxt = S_DONE;
      S_RD: begin
        if (op_r == OP_MATCH) state_nxt = S_SCAN;
        else if (op_r == OP_POP_HEAD && !closed_sel && nsel > CntBits'(1))
          state_nxt = S_SHIFT_RD;
        else state_nxt = S_DONE;
      end
      S_SCAN:  if (scan_end) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (best_r[TimeBits-1:0] > TimeBits'(maxd_r)) ? S_DONE : S_SHIFT_RD;
      S_SHIFT_RD: begin
        if (sh_r + 1'b1 >= shfill) state_nxt = sh_both_r ? S_SHIFT_RD : S_DONE;
        else state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_DONE:  state_nxt = (ov_r && !out_tready) ? S_DONE : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory addressing
  always_comb begin
    req = '0;
    req.wq = q_r;
    req.waddr = nsel[IdxBits-1:0];
    req.whandle = hin_r;
    req.wtime = enq_time;
    unique case (state_r)
      S_PRE: begin
        req.raddr0 = (op_r == OP_POP_TAIL) ? IdxBits'(fill0_r - 1'b1) : '0;
        req.raddr1 = (op_r == OP_POP_TAIL) ? IdxBits'(fill1_r - 1'b1) : '0;
      end
      S_MUL: req.we = 1'b1;
      S_RD: begin
        req.raddr0 = i_r;
        req.raddr1 = j_r;
      end
      S_SCAN: begin
        // on the last pair fetch the winning entries for the decision
        if (scan_end) begin
          req.raddr0 = better ? i_r : bi_r;
          req.raddr1 = better ? j_r : bj_r;
        end else begin
          req.raddr0 = last_j ? i_r + 1'b1 : i_r;
          req.raddr1 = last_j ? '0 : j_r + 1'b1;
        end
      end
      S_DECIDE: begin
        req.raddr0 = bi_r;
        req.raddr1 = bj_r;
      end
      S_SHIFT_RD: begin
        req.raddr0 = IdxBits'(sh_r + 1'b1);
        req.raddr1 = IdxBits'(sh_r + 1'b1);
      end
      S_SHIFT_WR: begin
        req.we = 1'b1;
        req.wq = shq_r;
        req.waddr = sh_r[IdxBits-1:0];
        req.whandle = shq_r ? rsp.h1 : rsp.h0;
        req.wtime = shq_r ? rsp.t1 : rsp.t0;
      end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill0_r <= '0; fill1_r <= '0;
      closed0_r <= 1'b0; closed1_r <= 1'b0;
      sh_both_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r <= op_t'(in_tdata[2:0]);
          q_r <= in_tdata[3];
          hin_r <= in_tdata[19:4];
          sec_r <= in_tdata[51:20];
          usec_r <= in_tdata[71:52];
          st_r <= ST_OK; ha_r <= '0; hb_r <= '0; dl_r <= '0;
          i_r <= '0; j_r <= '0; bi_r <= '0; bj_r <= '0;
          best_r <= {1'b1, {TimeBits{1'b0}}};
          sh_both_r <= 1'b0;
        end
        S_PRE: begin
          prod_r <= TimeBits'(sec_r) * TimeBits'(UsecPerSec);
          unique case (op_r)
            OP_ENQ: begin
              if (closed_sel) st_r <= ST_CLOSED;
              else if (!cap_ok) st_r <= ST_FULL;
            end
            OP_MATCH: if (fill0_r == '0 || fill1_r == '0) st_r <= ST_EMPTY;
            OP_CLEAR: begin
              if (q_r) begin fill1_r <= '0; closed1_r <= 1'b1; end
              else begin fill0_r <= '0; closed0_r <= 1'b1; end
            end
            OP_INIT: begin
              if (q_r) begin fill1_r <= '0; closed1_r <= 1'b0; end
              else begin fill0_r <= '0; closed0_r <= 1'b0; end
            end
            default: ;
          endcase
        end
        S_MUL: begin
          // write happens this cycle with the finished time
          if (q_r) fill1_r <= fill1_r + 1'b1;
          else fill0_r <= fill0_r + 1'b1;
        end
        S_RD: begin
          if (op_r != OP_MATCH) begin
            if (closed_sel) st_r <= ST_CLOSED;
            else if (nsel == '0) st_r <= ST_EMPTY;
            else begin
              ha_r <= q_r ? rsp.h1 : rsp.h0;
              // pop head with more entries drops the fill after compaction
              if (op_r == OP_POP_TAIL ||
                  (op_r == OP_POP_HEAD && nsel == CntBits'(1))) begin
                if (q_r) fill1_r <= fill1_r - 1'b1;
                else fill0_r <= fill0_r - 1'b1;
              end
              shq_r <= q_r;
              sh_r <= '0;
            end
          end
        end
        S_SCAN: begin
          best_r <= best_nxt;
          if (better) begin bi_r <= i_r; bj_r <= j_r; end
          if (last_j) begin
            j_r <= '0; i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        S_DECIDE: begin
          dl_r <= best_r[TimeBits-1:0];
          if (best_r[TimeBits-1:0] > TimeBits'(maxd_r)) st_r <= ST_NOMATCH;
          else begin
            ha_r <= rsp.h0; hb_r <= rsp.h1;
            // compaction runs over original fills; fills drop at the end
            shq_r <= 1'b0; sh_r <= {1'b0, bi_r};
            sh_both_r <= 1'b1;
          end
        end
        S_SHIFT_RD: begin
          if (sh_r + 1'b1 >= shfill) begin
            if (op_r == OP_MATCH || op_r == OP_POP_HEAD) begin
              if (shq_r) fill1_r <= fill1_r - 1'b1;
              else fill0_r <= fill0_r - 1'b1;
            end
            if (sh_both_r) begin
              sh_both_r <= 1'b0; shq_r <= 1'b1; sh_r <= {1'b0, bj_r};
            end
          end
        end
        S_SHIFT_WR: sh_r <= sh_r + 1'b1;
        default: ;
      endcase
    end
  end

  // enqueue time = sec*1e6 + usec, added after the registered multiply
  logic [TimeBits-1:0] enq_time;
  assign enq_time = prod_r + TimeBits'(usec_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (state_r == S_DONE && !(ov_r && !out_tready)) begin
      ov_r <= 1'b1;
      od_r <= {4'b0, (q_r ? fill1_r : fill0_r), dl_r, hb_r, ha_r, st_r};
    end else if (out_tready) ov_r <= 1'b0;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  `FDQ_ASSERT(a_fill0_bound, fill0_r <= CntBits'(QueueDepth), "queue 0 fill over depth")
  `FDQ_ASSERT(a_fill1_bound, fill1_r <= CntBits'(QueueDepth), "queue 1 fill over depth")
  `FDQ_ASSERT_NEXT(a_done_valid, state_r == S_DONE, out_tvalid, "result lost")
endmodule
`default_nettype wire

// File: design/fdq_store.sv
`default_nettype none
// Two descriptor memories, one per queue, each with one write and one read port.
module fdq_store import fdq_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output mem_rsp_t      rsp
);
  logic [HandleBits-1:0] h0_mem [QueueDepth];
  logic [TimeBits-1:0]   t0_mem [QueueDepth];
  logic [HandleBits-1:0] h1_mem [QueueDepth];
  logic [TimeBits-1:0]   t1_mem [QueueDepth];

  // queue 0 and queue 1 memories
  always_ff @(posedge clk) begin
    if (req.we && !req.wq) begin
      h0_mem[req.waddr] <= req.whandle;
      t0_mem[req.waddr] <= req.wtime;
    end
    if (req.we && req.wq) begin
      h1_mem[req.waddr] <= req.whandle;
      t1_mem[req.waddr] <= req.wtime;
    end
    rsp.h0 <= h0_mem[req.raddr0];
    rsp.t0 <= t0_mem[req.raddr0];
    rsp.h1 <= h1_mem[req.raddr1];
    rsp.t1 <= t1_mem[req.raddr1];
  end
endmodule
`default_nettype wire

// File: test/frame_deque_pair_timestamp_matcher_unit_checker.sv
`timescale 1ns / 1ps
module frame_deque_pair_timestamp_matcher_unit_checker import fdq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  // fields from the highest bit down, status in the lowest bits
  typedef struct packed {
    logic [4:0]  count;
    logic [51:0] delta;
    logic [15:0] handle_b;
    logic [15:0] handle_a;
    logic [2:0]  status;
  } outcome_t;

  // shadow copy of the block state
  logic [4:0]  cap [2];
  logic [19:0] early_lim, max_lim;
  logic [15:0] hq [2][$];
  logic [51:0] tq [2][$];
  logic        closed [2];
  outcome_t    outcomes_due [$];

  assign pending = outcomes_due.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic int cap_of(input int q);
    return (cap[q] > QueueDepth) ? QueueDepth : cap[q];
  endfunction

  // compute the outcome of one operation and update the shadow state
  function automatic outcome_t apply_op(input logic [71:0] d);
    outcome_t o;
    op_t op;
    int q, n, bi, bj;
    logic [51:0] t0, t1, dd;
    logic [63:0] best;
    o = '0;
    op = op_t'(d[2:0]);
    q = d[3];
    n = hq[q].size();
    case (op)
      OP_ENQ: begin
        if (closed[q]) o.status = ST_CLOSED;
        else if (n >= cap_of(q)) o.status = ST_FULL;
        else begin
          hq[q].push_back(d[19:4]);
          tq[q].push_back(52'(d[51:20]) * 52'd1000000 + 52'(d[71:52]));
        end
      end
      OP_POP_HEAD, OP_POP_TAIL, OP_PEEK: begin
        if (closed[q]) o.status = ST_CLOSED;
        else if (n == 0) o.status = ST_EMPTY;
        else if (op == OP_POP_TAIL) begin
          o.handle_a = hq[q].pop_back();
          void'(tq[q].pop_back());
        end else begin
          o.handle_a = hq[q][0];
          if (op == OP_POP_HEAD) begin
            void'(hq[q].pop_front());
            void'(tq[q].pop_front());
          end
        end
      end
      OP_MATCH: begin
        if (hq[0].size() == 0 || hq[1].size() == 0) o.status = ST_EMPTY;
        else begin
          best = '1;
          bi = 0;
          bj = 0;
          for (int i = 0; i < hq[0].size(); i++) begin
            t0 = tq[0][i];
            for (int j = 0; j < hq[1].size(); j++) begin
              t1 = tq[1][j];
              dd = (t1 >= t0) ? t1 - t0 : t0 - t1;
              if (64'(dd) < best) begin
                best = 64'(dd);
                bi = i;
                bj = j;
              end
            end
            if (best < 64'(early_lim)) break;
          end
          o.delta = best[51:0];
          if (best > 64'(max_lim)) o.status = ST_NOMATCH;
          else begin
            o.handle_a = hq[0][bi];
            o.handle_b = hq[1][bj];
            hq[0].delete(bi);
            tq[0].delete(bi);
            hq[1].delete(bj);
            tq[1].delete(bj);
          end
        end
      end
      OP_CLEAR, OP_INIT: begin
        hq[q].delete();
        tq[q].delete();
        closed[q] = (op == OP_CLEAR);
      end
      default: ;
    endcase
    o.count = 5'(hq[q].size());
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t w, g;
    if (!rst_n) begin
      cap[0] <= 5'd16;
      cap[1] <= 5'd16;
      early_lim <= 20'd400;
      max_lim <= 20'd50000;
      closed[0] = 1'b0;
      closed[1] = 1'b0;
      hq[0].delete(); hq[1].delete(); tq[0].delete(); tq[1].delete();
      outcomes_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (reg_t'(cfg_index))
          REG_CAP0:  cap[0] <= cfg_data[4:0];
          REG_CAP1:  cap[1] <= cfg_data[4:0];
          REG_EARLY: early_lim <= cfg_data;
          REG_MAXD:  max_lim <= cfg_data;
          default: ;
        endcase
      end
      // result beat against oldest expectation
      if (out_tvalid && out_tready) begin
        g = out_tdata[91:0];
        if (outcomes_due.size() == 0) report("unexpected beat", g.status, 0);
        else begin
          w = outcomes_due.pop_front();
          if (g.status !== w.status) report("status", g.status, w.status);
          if (g.handle_a !== w.handle_a) report("handle_a", g.handle_a, w.handle_a);
          if (g.handle_b !== w.handle_b) report("handle_b", g.handle_b, w.handle_b);
          if (g.delta !== w.delta) report("delta_us", g.delta, w.delta);
          if (g.count !== w.count) report("entry_count", g.count, w.count);
        end
      end
      if (in_tvalid && in_tready) outcomes_due.push_back(apply_op(in_tdata));
    end
  end
endmodule

// File: test/frame_deque_pair_timestamp_matcher_unit_tb.sv
`timescale 1ns / 1ps
module frame_deque_pair_timestamp_matcher_unit_tb import fdq_pkg::*;;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          hold_off = 1'b0;
  bit          stall_free = 1'b0;

  always #5 clk = ~clk;

  frame_deque_pair_timestamp_matcher_unit i_dut (.*);

  frame_deque_pair_timestamp_matcher_unit_checker i_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (stall_free) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [71:0] make_beat(input op_t op, input bit q,
                                            input logic [15:0] h,
                                            input logic [31:0] s,
                                            input logic [19:0] u);
    return {u, s, h, q, 3'(op)};
  endfunction

  // send one beat, with bursty gaps; valid stays up until the next call or a drain
  task automatic send(input logic [71:0] d);
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_t idx, input logic [19:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random operation with a time near a base so matches succeed often
  task automatic send_random(input logic [31:0] base_sec);
    int r;
    op_t op;
    logic [31:0] s;
    logic [19:0] u;
    r = $urandom_range(0, 99);
    if (r < 45) op = OP_ENQ;
    else if (r < 55) op = OP_POP_HEAD;
    else if (r < 62) op = OP_POP_TAIL;
    else if (r < 69) op = OP_PEEK;
    else if (r < 88) op = OP_MATCH;
    else if (r < 92) op = OP_CLEAR;
    else if (r < 98) op = OP_INIT;
    else op = OP_NONE;
    if ($urandom_range(0, 9) == 0) begin
      s = $urandom;
      u = 20'($urandom);
    end else begin
      s = base_sec + $urandom_range(0, 1);
      u = 20'($urandom_range(0, 999999));
    end
    send(make_beat(op, 1'($urandom_range(0, 1)), 16'($urandom), s, u));
  endtask

  initial begin
    logic [31:0] base;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and the empty, closed and no-match cases
    send(make_beat(OP_POP_HEAD, 0, 0, 0, 0));
    send(make_beat(OP_MATCH, 0, 0, 0, 0));
    send(make_beat(OP_ENQ, 0, 16'hffff, 32'hffffffff, 20'hfffff));
    send(make_beat(OP_MATCH, 1, 0, 0, 0));
    send(make_beat(OP_ENQ, 1, 16'h0000, 32'h0, 20'h0));
    send(make_beat(OP_MATCH, 0, 0, 0, 0));
    send(make_beat(OP_ENQ, 1, 16'h1234, 32'hffffffff, 20'hffff0));
    send(make_beat(OP_PEEK, 0, 0, 0, 0));
    send(make_beat(OP_MATCH, 1, 0, 0, 0));
    send(make_beat(OP_ENQ, 0, 16'h0a0a, 32'd5, 20'd10));
    send(make_beat(OP_ENQ, 1, 16'h0b0b, 32'd5, 20'd20));
    send(make_beat(OP_POP_TAIL, 1, 0, 0, 0));
    send(make_beat(OP_CLEAR, 0, 0, 0, 0));
    send(make_beat(OP_ENQ, 0, 16'h5555, 32'd1, 20'd1));
    send(make_beat(OP_POP_HEAD, 0, 0, 0, 0));
    send(make_beat(OP_INIT, 0, 0, 0, 0));
    send(make_beat(OP_NONE, 1, 16'hffff, 32'hffffffff, 20'hfffff));
    send(make_beat(OP_CLEAR, 1, 0, 0, 0));
    send(make_beat(OP_INIT, 1, 0, 0, 0));
    drain();

    // long receiver hold-off while offering beats
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 20; k++) send_random(32'd100);
    join
    drain();

    // phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CAP0, 20'd0); write_reg(REG_CAP1, 20'd31);
          write_reg(REG_EARLY, 20'd0); write_reg(REG_MAXD, 20'hfffff);
        end
        1: begin
          write_reg(REG_CAP0, 20'd16); write_reg(REG_CAP1, 20'd1);
          write_reg(REG_EARLY, 20'hfffff); write_reg(REG_MAXD, 20'd0);
        end
        2: begin
          write_reg(REG_CAP0, 20'd3); write_reg(REG_CAP1, 20'd17);
          write_reg(REG_EARLY, 20'd1000); write_reg(REG_MAXD, 20'd300000);
        end
        3: begin
          write_reg(REG_CAP0, 20'd31); write_reg(REG_CAP1, 20'd0);
          write_reg(REG_EARLY, 20'd400); write_reg(REG_MAXD, 20'd50000);
        end
        default: begin
          write_reg(REG_CAP0, 20'($urandom_range(0, 31)));
          write_reg(REG_CAP1, 20'($urandom_range(4, 31)));
          write_reg(REG_EARLY, 20'($urandom_range(0, 200000)));
          write_reg(REG_MAXD, 20'($urandom_range(0, 1048575)));
        end
      endcase
      base = $urandom;
      stall_free = (ph == 3);
      for (int k = 0; k < 165; k++) send_random(base);
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
